### sv/decimal_and_boolean_value_parser_defines.svh
// ----------------------------------------------------------------------------
// Value parser assertion macros
// Shared concurrent assertion forms, clocked on clock; all but the next-cycle form are gated by reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_AND_BOOLEAN_VALUE_PARSER_DEFINES_SVH
`define DECIMAL_AND_BOOLEAN_VALUE_PARSER_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define DBVP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define DBVP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define DBVP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

### sv/dbvp_pkg.sv
// ----------------------------------------------------------------------------
// Value parser package
// Codes, character constants, keyword tables and the step structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dbvp_pkg;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned EXT_W     = VALUE_W + 4;
   localparam int unsigned KW_COUNT  = 8;
   localparam int unsigned KW_HALF   = 4;
   localparam int unsigned KW_COLS   = 8;

   typedef logic [2:0] count_type;

   localparam count_type CNT_MAX = 3'd6;

   // Value kinds.
   localparam logic [1:0] KIND_SIGNED   = 2'd0;
   localparam logic [1:0] KIND_UNSIGNED = 2'd1;
   localparam logic [1:0] KIND_BOOLEAN  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_INT  = 2'd1;
   localparam logic [1:0] STATUS_BAD_BOOL = 2'd2;

   // Characters.
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [EXT_W-1:0] LIMIT_POS      = 68'h0_7FFF_FFFF_FFFF_FFFF;
   localparam logic [EXT_W-1:0] LIMIT_NEG      = 68'h0_8000_0000_0000_0000;
   localparam logic [EXT_W-1:0] LIMIT_UNSIGNED = 68'h0_FFFF_FFFF_FFFF_FFFF;

   // Keywords in mask order: true yes on 1 false no off 0. The first half
   // yields one, the second half zero.
   localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:KW_COLS-1] = '{
      '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h79, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
      '{8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6F, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam count_type KW_LEN [0:KW_COUNT-1] = '{
      3'd4, 3'd3, 3'd2, 3'd1, 3'd5, 3'd2, 3'd3, 3'd1
   };

   typedef struct packed {
      logic               minus;
      logic               fail;
      logic [VALUE_W-1:0] acc;
      logic [VALUE_W-1:0] nacc;
   } digit_step_type;

   typedef struct packed {
      logic [KW_COUNT-1:0] mask;
      logic                hit_true;
      logic                hit_false;
   } keyword_step_type;

endpackage

`default_nettype wire

### sv/dbvp_digit_step.sv
// ----------------------------------------------------------------------------
// Decimal digit step
// Multiply-by-ten and add for one character, with the range check and a
// negated copy of the accumulator kept in step.
// ----------------------------------------------------------------------------
`default_nettype none

module dbvp_digit_step (
   input  wire logic [7:0]                   ch,
   input  wire logic                         is_signed,
   input  wire logic                         first,
   input  wire logic                         negative_seen,
   input  wire logic [dbvp_pkg::VALUE_W-1:0] acc,
   input  wire logic [dbvp_pkg::VALUE_W-1:0] nacc,
   output dbvp_pkg::digit_step_type          step
);

   logic [3:0]                   digit;
   logic                         is_digit;
   logic [dbvp_pkg::EXT_W-1:0]   acc_ext;
   logic [dbvp_pkg::EXT_W-1:0]   product;
   logic [dbvp_pkg::EXT_W-1:0]   limit;

   assign digit    = ch[3:0];
   assign is_digit = (ch >= dbvp_pkg::CH_ZERO) && (ch <= dbvp_pkg::CH_NINE);
   assign acc_ext  = {4'b0, acc};

   // The product cannot wrap in the extended width, so a compare against the
   // limit replaces the division in the overflow test.
   assign product = (acc_ext << 3) + (acc_ext << 1) +
                    {{(dbvp_pkg::EXT_W-4){1'b0}}, digit};

   always_comb begin
      if (!is_signed) begin
         limit = dbvp_pkg::LIMIT_UNSIGNED;
      end else if (negative_seen) begin
         limit = dbvp_pkg::LIMIT_NEG;
      end else begin
         limit = dbvp_pkg::LIMIT_POS;
      end
   end

   always_comb begin
      step.minus = is_signed && first && (ch == dbvp_pkg::CH_MINUS);
      step.fail  = !step.minus && (!is_digit || (product > limit));
      step.acc   = product[dbvp_pkg::VALUE_W-1:0];
      step.nacc  = (nacc << 3) + (nacc << 1) -
                   {{(dbvp_pkg::VALUE_W-4){1'b0}}, digit};
   end

endmodule

`default_nettype wire

### sv/dbvp_keyword_match.sv
// ----------------------------------------------------------------------------
// Boolean keyword matcher
// Narrows the candidate mask by one case-folded character and reports
// whether a true or false keyword ends at the current length.
// ----------------------------------------------------------------------------
`default_nettype none

module dbvp_keyword_match (
   input  wire logic [7:0]                    ch,
   input  wire logic                          take,
   input  wire dbvp_pkg::count_type           idx,
   input  wire dbvp_pkg::count_type           count_next,
   input  wire logic [dbvp_pkg::KW_COUNT-1:0] mask,
   output dbvp_pkg::keyword_step_type         step
);

   logic [7:0]                    lower;
   logic [dbvp_pkg::KW_COUNT-1:0] narrowed;
   logic [dbvp_pkg::KW_COUNT-1:0] len_hit;

   assign lower = ((ch >= dbvp_pkg::CH_UPPER_A) && (ch <= dbvp_pkg::CH_UPPER_Z)) ?
                  (ch + dbvp_pkg::CASE_OFFSET) : ch;

   always_comb begin
      for (int k = 0; k < dbvp_pkg::KW_COUNT; k++) begin
         narrowed[k] = mask[k] && (idx < dbvp_pkg::KW_LEN[k]) &&
                       (dbvp_pkg::KW_TEXT[k][idx] == lower);
         len_hit[k]  = (dbvp_pkg::KW_LEN[k] == count_next);
      end
   end

   always_comb begin
      step.mask      = take ? narrowed : mask;
      step.hit_true  = |(step.mask[dbvp_pkg::KW_HALF-1:0] &
                         len_hit[dbvp_pkg::KW_HALF-1:0]);
      step.hit_false = |(step.mask[dbvp_pkg::KW_COUNT-1:dbvp_pkg::KW_HALF] &
                         len_hit[dbvp_pkg::KW_COUNT-1:dbvp_pkg::KW_HALF]);
   end

endmodule

`default_nettype wire

### sv/decimal_and_boolean_value_parser.sv
// The final request of a string goes from the input register to the result
// register, waiting while a stalled response holds that register. One request
// per cycle but for that wait; the per-character digit step (multiply by ten,
// add, limit compare) sits between the input register and the result register.
// Only the final request of a string needs room in the result register.
// Synchronous active-high reset clears all parse state and both valid flags.
// ----------------------------------------------------------------------------
// Decimal and boolean value parser
// Parses one value string, a character per request, into a 64-bit signed or
// unsigned integer or a boolean, with malformed and overflow detection.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_and_boolean_value_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_ch,
   input  wire logic [1:0]                   req_operation,
   input  wire logic                         req_last,
   input  wire logic                         req_empty_req,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [dbvp_pkg::VALUE_W-1:0]      rsp_value
);

   // Input register.
   logic                  hold_valid_ff;
   logic [7:0]            hold_ch_ff;
   logic [1:0]            hold_op_ff;
   logic                  hold_last_ff;
   logic                  hold_empty_ff;

   // Parse state.
   logic [dbvp_pkg::VALUE_W-1:0]  acc_ff,    acc_in;
   logic [dbvp_pkg::VALUE_W-1:0]  nacc_ff,   nacc_in;
   logic                          neg_ff,    neg_in;
   logic [1:0]                    kind_ff,   kind_in;
   dbvp_pkg::count_type           cnt_ff,    cnt_in;
   logic                          failed_ff, failed_in;
   logic [dbvp_pkg::KW_COUNT-1:0] mask_ff,   mask_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [dbvp_pkg::VALUE_W-1:0]  rsp_value_ff,  rsp_value_in;

   logic                          advance;
   logic                          out_free;
   logic                          first;
   logic                          take_char;
   logic                          int_take;
   logic                          bool_take;
   logic                          digit_ok;

   dbvp_pkg::digit_step_type      dstep;
   dbvp_pkg::keyword_step_type    kstep;

   // A request that ends a string needs the result register; others move on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = hold_valid_ff && (!hold_last_ff || out_free);
   assign req_stall = hold_valid_ff && !advance;

   assign first     = (cnt_ff == '0);
   assign kind_in   = first ? hold_op_ff : kind_ff;
   assign take_char = !hold_empty_ff;
   assign int_take  = take_char && !failed_ff &&
                      ((kind_in == dbvp_pkg::KIND_SIGNED) ||
                       (kind_in == dbvp_pkg::KIND_UNSIGNED));
   assign bool_take = take_char && (kind_in == dbvp_pkg::KIND_BOOLEAN);
   assign digit_ok  = int_take && !dstep.minus && !dstep.fail;

   dbvp_digit_step u_digit_step (
      .ch            (hold_ch_ff),
      .is_signed     (kind_in == dbvp_pkg::KIND_SIGNED),
      .first         (first),
      .negative_seen (neg_ff),
      .acc           (acc_ff),
      .nacc          (nacc_ff),
      .step          (dstep)
   );

   dbvp_keyword_match u_keyword_match (
      .ch         (hold_ch_ff),
      .take       (bool_take),
      .idx        (cnt_ff),
      .count_next (cnt_in),
      .mask       (mask_ff),
      .step       (kstep)
   );

   always_comb begin
      cnt_in    = (take_char && (cnt_ff != dbvp_pkg::CNT_MAX)) ? (cnt_ff + 3'd1) : cnt_ff;
      neg_in    = neg_ff | (int_take && dstep.minus);
      failed_in = failed_ff | (int_take && dstep.fail);
      acc_in    = digit_ok ? dstep.acc  : acc_ff;
      nacc_in   = digit_ok ? dstep.nacc : nacc_ff;
   end

   assign mask_in = kstep.mask;

   always_comb begin
      rsp_status_in = dbvp_pkg::STATUS_OK;
      rsp_value_in  = '0;
      case (kind_in) inside
         dbvp_pkg::KIND_SIGNED, dbvp_pkg::KIND_UNSIGNED: begin
            // A string holding only the minus sign is as bad as an empty one.
            if (failed_in || (cnt_in == '0) || (neg_in && (cnt_in == 3'd1))) begin
               rsp_status_in = dbvp_pkg::STATUS_BAD_INT;
            end else begin
               rsp_value_in = neg_in ? nacc_in : acc_in;
            end
         end
         dbvp_pkg::KIND_BOOLEAN: begin
            if (kstep.hit_true) begin
               rsp_value_in = {{(dbvp_pkg::VALUE_W-1){1'b0}}, 1'b1};
            end else if (!kstep.hit_false) begin
               rsp_status_in = dbvp_pkg::STATUS_BAD_BOOL;
            end
         end
         default: begin
            rsp_status_in = dbvp_pkg::STATUS_BAD_INT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         hold_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         hold_ch_ff    <= req_ch;
         hold_op_ff    <= req_operation;
         hold_last_ff  <= req_last;
         hold_empty_ff <= req_empty_req;
      end
   end

   // State returns to its reset value after each completed string.
   always_ff @(posedge clock) begin
      if (reset || (advance && hold_last_ff)) begin
         acc_ff    <= '0;
         nacc_ff   <= '0;
         neg_ff    <= 1'b0;
         kind_ff   <= dbvp_pkg::KIND_SIGNED;
         cnt_ff    <= '0;
         failed_ff <= 1'b0;
         mask_ff   <= '1;
      end else if (advance) begin
         acc_ff    <= acc_in;
         nacc_ff   <= nacc_in;
         neg_ff    <= neg_in;
         kind_ff   <= kind_in;
         cnt_ff    <= cnt_in;
         failed_ff <= failed_in;
         mask_ff   <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && hold_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hold_last_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

`default_nettype wire

### sv/dbvp_checker.sv
// ----------------------------------------------------------------------------
// Value parser port checker
// Watches the response channel of the parser and is bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_and_boolean_value_parser_defines.svh"

module dbvp_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [1:0]                   rsp_status,
   input wire logic [dbvp_pkg::VALUE_W-1:0] rsp_value
);

   // A failed parse never leaks partial digits.
   `DBVP_ASSERT_IMPLY(a_fail_zero, rsp_valid && (rsp_status != dbvp_pkg::STATUS_OK), rsp_value == '0, "failed response carries a nonzero value")

   `DBVP_ASSERT_IMPLY(a_status_code, rsp_valid, (rsp_status == dbvp_pkg::STATUS_OK) || (rsp_status == dbvp_pkg::STATUS_BAD_INT) || (rsp_status == dbvp_pkg::STATUS_BAD_BOOL), "response status is not a defined code")

   // Reset must drop any pending response.
   `DBVP_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid, "response valid right after reset")

   `DBVP_ASSERT_NEXT(a_stall_hold, !reset && rsp_valid && rsp_stall, reset || (rsp_valid && $stable(rsp_status) && $stable(rsp_value)), "stalled response changed")

endmodule

bind decimal_and_boolean_value_parser dbvp_checker u_dbvp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_value  (rsp_value)
);

`default_nettype wire

### dv/decimal_and_boolean_value_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal and boolean value parser testbench
// Streams value strings into the parser one character per request, predicts
// the status and value of every finished string, and checks each response in
// order while both sides idle and stall at random.
// ----------------------------------------------------------------------------

module decimal_and_boolean_value_parser_tb;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned TARGET_REQS  = 1100;
   localparam int unsigned SETTLE_TIME  = 20;

   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [63:0] MAX_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MAX_NEG_MAG  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_UNSIGNED = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef logic [7:0] text_type [$];

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] operation;
      logic       last;
      logic       empty_req;
      logic       drain_first;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value;
   } parse_result_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch        = 8'h00;
   logic [1:0]  req_operation = dbvp_pkg::KIND_SIGNED;
   logic        req_last      = 1'b0;
   logic        req_empty_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_value;

   decimal_and_boolean_value_parser u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_operation (req_operation),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value)
   );

   string kw_words [8] = '{"true", "yes", "on", "1", "false", "no", "off", "0"};
   string limit_texts [10] = '{
      "9223372036854775807", "9223372036854775808", "-9223372036854775808",
      "-9223372036854775809", "18446744073709551615", "18446744073709551616",
      "0", "-0", "000000000000000000000042", "99999999999999999999"
   };

   // Parser state as the predictor sees it.
   logic [63:0]         acc_value;
   logic                minus_seen;
   logic [1:0]          kind_held;
   dbvp_pkg::count_type char_total;
   logic                parse_failed;
   logic [7:0]          word_mask;

   req_item_type     pending_reqs [$];
   parse_result_type expected_values [$];
   bit               hold_next;
   int unsigned      queued_reqs;

   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned accepted_reqs;
   int unsigned checked_rsps;
   int unsigned ok_ints;
   int unsigned ok_bools;
   int unsigned rejects;

   logic             req_taken;
   int unsigned      send_gap;
   int unsigned      send_calm;
   int unsigned      stall_left;
   int unsigned      stall_calm;
   req_item_type     next_req;
   parse_result_type predicted;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void clear_parser();
      acc_value    = '0;
      minus_seen   = 1'b0;
      kind_held    = dbvp_pkg::KIND_SIGNED;
      char_total   = '0;
      parse_failed = 1'b0;
      word_mask    = 8'hFF;
   endfunction

   // Advances the predicted parser by one request; returns 1 when the request
   // closes a string, with the expected response in res.
   function automatic bit parse_request(input req_item_type rq,
                                        output parse_result_type res);
      logic [7:0]  c;
      logic [63:0] digit;
      logic [63:0] bound;
      bit          found;
      res = '0;
      found = 1'b0;
      if (char_total == 0) kind_held = rq.operation;
      if (!rq.empty_req) begin
         c = rq.ch;
         if (kind_held == dbvp_pkg::KIND_SIGNED || kind_held == dbvp_pkg::KIND_UNSIGNED) begin
            if (!parse_failed) begin
               if (kind_held == dbvp_pkg::KIND_SIGNED && char_total == 0 &&
                   c == dbvp_pkg::CH_MINUS) begin
                  minus_seen = 1'b1;
               end else if (c < dbvp_pkg::CH_ZERO || c > dbvp_pkg::CH_NINE) begin
                  parse_failed = 1'b1;
               end else begin
                  digit = {56'd0, c} - {56'd0, dbvp_pkg::CH_ZERO};
                  if (kind_held == dbvp_pkg::KIND_UNSIGNED) bound = MAX_UNSIGNED;
                  else bound = minus_seen ? MAX_NEG_MAG : MAX_POSITIVE;
                  if (acc_value > (bound - digit) / 64'd10) parse_failed = 1'b1;
                  else acc_value = acc_value * 64'd10 + digit;
               end
            end
         end else if (kind_held == dbvp_pkg::KIND_BOOLEAN) begin
            if (c >= dbvp_pkg::CH_UPPER_A && c <= dbvp_pkg::CH_UPPER_Z)
               c = c + dbvp_pkg::CASE_OFFSET;
            for (int k = 0; k < 8; k++) begin
               if (char_total >= kw_words[k].len() || kw_words[k][char_total] != c)
                  word_mask[k] = 1'b0;
            end
         end
         if (char_total < dbvp_pkg::CNT_MAX) char_total = char_total + 1'b1;
      end
      if (!rq.last) return 1'b0;
      if (kind_held == dbvp_pkg::KIND_SIGNED || kind_held == dbvp_pkg::KIND_UNSIGNED) begin
         if (parse_failed || char_total == 0 || (minus_seen && char_total == 1))
            res.status = dbvp_pkg::STATUS_BAD_INT;
         else
            res.value = minus_seen ? 64'd0 - acc_value : acc_value;
      end else if (kind_held == dbvp_pkg::KIND_BOOLEAN) begin
         res.status = dbvp_pkg::STATUS_BAD_BOOL;
         for (int k = 0; k < 8; k++) begin
            if (!found && word_mask[k] && kw_words[k].len() == char_total) begin
               found = 1'b1;
               res.status = dbvp_pkg::STATUS_OK;
               res.value = (k < 4) ? 64'd1 : 64'd0;
            end
         end
      end else begin
         res.status = dbvp_pkg::STATUS_BAD_INT;
      end
      clear_parser();
      return 1'b1;
   endfunction

   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic text_type text_of(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   // Rough split for the summary only: boolean results are 0 or 1.
   function automatic bit kind_held_last_bool(input parse_result_type res);
      return res.value <= 64'd1;
   endfunction

   task automatic push_req(input req_item_type rq);
      rq.drain_first = hold_next;
      hold_next = 1'b0;
      queued_reqs++;
      pending_reqs.push_back(rq);
   endtask

   task automatic push_blank(input logic last);
      req_item_type rq;
      rq.ch        = 8'($urandom_range(0, 255));
      rq.operation = 2'($urandom_range(0, 3));
      rq.last      = last;
      rq.empty_req = 1'b1;
      push_req(rq);
   endtask

   // Queues one value string; with sprinkle set, requests without a character
   // are slipped in at random, including now and then as the closing request.
   task automatic queue_text(input logic [1:0] kind, input text_type t, input bit sprinkle);
      req_item_type rq;
      bit           tail_blank;
      tail_blank = sprinkle && ($urandom_range(0, 19) == 0);
      for (int i = 0; i < t.size(); i++) begin
         if (sprinkle && $urandom_range(0, 19) == 0) push_blank(1'b0);
         rq.ch        = t[i];
         rq.operation = (i == 0) ? kind : 2'($urandom_range(0, 3));
         rq.last      = (i == t.size() - 1) && !tail_blank;
         rq.empty_req = 1'b0;
         push_req(rq);
      end
      if (tail_blank) push_blank(1'b1);
   endtask

   task automatic add_decimal();
      logic [63:0] v;
      logic [1:0]  kind;
      text_type    t;
      string       s;
      int unsigned r;
      kind = $urandom_range(0, 1) ? dbvp_pkg::KIND_UNSIGNED : dbvp_pkg::KIND_SIGNED;
      v = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 35) v = v >> $urandom_range(0, 63);
      if (kind == dbvp_pkg::KIND_SIGNED) s = $sformatf("%0d", $signed(v));
      else s = $sformatf("%0d", v);
      if (r >= 35 && r < 55) s = limit_texts[$urandom_range(0, 9)];
      t = text_of(s);
      r = $urandom_range(0, 99);
      if (r < 12) begin
         t.push_back(8'($urandom_range(dbvp_pkg::CH_ZERO, dbvp_pkg::CH_NINE)));
      end else if (r < 20) begin
         t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 25) begin
         t.insert($urandom_range(0, t.size()), dbvp_pkg::CH_MINUS);
      end else if (r < 30) begin
         t.push_front(dbvp_pkg::CH_ZERO);
      end
      queue_text(kind, t, 1'b1);
   endtask

   task automatic add_boolean();
      text_type    t;
      int unsigned r;
      t = text_of(kw_words[$urandom_range(0, 7)]);
      for (int i = 0; i < t.size(); i++) begin
         if (t[i] >= dbvp_pkg::CH_UPPER_A + dbvp_pkg::CASE_OFFSET && $urandom_range(0, 1))
            t[i] = t[i] - dbvp_pkg::CASE_OFFSET;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 14) begin
         t.push_back(8'($urandom_range(dbvp_pkg::CH_UPPER_A, dbvp_pkg::CH_UPPER_Z)));
      end else if (r < 18 && t.size() > 1) begin
         void'(t.pop_back());
      end else if (r < 21) begin
         for (int i = 0; i < 3; i++) t.push_back(t[i % t.size()]);
      end
      queue_text(dbvp_pkg::KIND_BOOLEAN, t, 1'b1);
   endtask

   task automatic add_noise();
      text_type t;
      repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
      queue_text(2'($urandom_range(0, 3)), t, 1'b1);
   endtask

   // Request driver: presents the next pending request once the previous one is
   // taken, its idle gap has run out and any drain it asks for is complete.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain_first && expected_values.size() != 0)) begin
            next_req = pending_reqs.pop_front();
            req_ch        <= next_req.ch;
            req_operation <= next_req.operation;
            req_last      <= next_req.last;
            req_empty_req <= next_req.empty_req;
            req_valid     <= 1'b1;
            if (send_calm != 0) begin
               send_calm <= send_calm - 1;
               send_gap <= 0;
            end else begin
               send_gap <= pick_idle();
               if ($urandom_range(0, 59) == 0) send_calm <= $urandom_range(30, 120);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm != 0) begin
            stall_calm <= stall_calm - 1;
         end else begin
            stall_left <= pick_idle();
            if ($urandom_range(0, 49) == 0) stall_calm <= $urandom_range(30, 120);
         end
      end
   end

   // Monitor: checks responses against the oldest expectation, then predicts
   // the request taken at this edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected response, status %0d value %h",
                        $time, rsp_status, rsp_value);
               error_count++;
            end else begin
               predicted = expected_values.pop_front();
               checked_rsps++;
               if (rsp_status !== predicted.status) begin
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, predicted.status, rsp_status);
                  error_count++;
               end
               if (rsp_value !== predicted.value) begin
                  $display("%0t: value mismatch: expected %h, got %h",
                           $time, predicted.value, rsp_value);
                  error_count++;
               end
               if (predicted.status != dbvp_pkg::STATUS_OK) rejects++;
               else if (kind_held_last_bool(predicted)) ok_bools++;
               else ok_ints++;
            end
         end
         if (req_valid && !req_stall) begin
            accepted_reqs++;
            if (parse_request({req_ch, req_operation, req_last, req_empty_req, 1'b0},
                              predicted))
               expected_values.push_back(predicted);
         end
      end
   end

   initial begin
      text_type t;
      clear_parser();
      hold_next = 1'b0;

      // Directed strings.
      push_blank(1'b1);                                  // empty string
      begin
         req_item_type rq;
         rq = '{ch: 8'h00, operation: dbvp_pkg::KIND_BOOLEAN, last: 1'b1,
                empty_req: 1'b1, drain_first: 1'b0};
         push_req(rq);                                   // empty boolean string
      end
      queue_text(dbvp_pkg::KIND_SIGNED, text_of("-"), 1'b0);       // lone minus
      queue_text(dbvp_pkg::KIND_UNSIGNED, text_of("-5"), 1'b0);    // minus not allowed
      queue_text(dbvp_pkg::KIND_SIGNED, text_of("4-"), 1'b0);      // minus not first
      queue_text(dbvp_pkg::KIND_BOOLEAN, text_of("TrUe"), 1'b0);
      queue_text(dbvp_pkg::KIND_BOOLEAN, text_of("OFF"), 1'b0);
      queue_text(dbvp_pkg::KIND_BOOLEAN, text_of("falsey"), 1'b0); // word too long
      t = {8'h00};
      queue_text(dbvp_pkg::KIND_SIGNED, t, 1'b0);                  // character code zero
      t = {8'hFF};
      queue_text(KIND_UNUSED, t, 1'b0);                            // unused kind
      queue_text(dbvp_pkg::KIND_BOOLEAN, text_of("0"), 1'b0);

      // Random strings; the sender drains the parser before this part and before
      // each string begun just past its midpoint.
      hold_next = 1'b1;
      while (queued_reqs < TARGET_REQS) begin
         if (queued_reqs > TARGET_REQS / 2 && queued_reqs < TARGET_REQS / 2 + 10)
            hold_next = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add_decimal();
            4, 5, 6:    add_boolean();
            7, 8:       add_noise();
            default:    push_blank(1'b1);
         endcase
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_values.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses.", accepted_reqs, checked_rsps);
      $display("Accepted integers or booleans: %0d and %0d; rejected strings: %0d.",
               ok_ints, ok_bools, rejects);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles.", cycle_count);
      $display("TB_ERROR");
      $finish;
   end

endmodule
